/* rtl/dsp_program_image_loader_defines.svh */
// Assertion macros shared by the RTL files
`ifndef DSP_PROGRAM_IMAGE_LOADER_DEFINES_SVH
`define DSP_PROGRAM_IMAGE_LOADER_DEFINES_SVH

// same-cycle implication
`define DPIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dpil_pkg.sv */
package dpil_pkg;

    localparam int WORD_W    = 16;
    localparam int DSP_W     = 2;
    localparam int OFFSET_W  = 22;
    localparam int KIND_W    = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [WORD_W-1:0]  TERMINATOR_WORD = 16'hFFFF;
    localparam int                 DATA_SPACE_BIT  = 14;
    localparam logic [PADDR_W-1:0] REG_DSP_INDEX   = 3'd0;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_HIGH
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA    = 2'd0,
        KIND_PROG_LO = 2'd1,
        KIND_PROG_HI = 2'd2
    } t_kind;

    typedef struct packed {
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] low_word;
        logic [WORD_W-1:0] value;
        logic              two_writes;
    } t_cmd;

endpackage

/* rtl/dpil_ifs.sv */
interface dpil_word_if;
    logic                          valid;
    logic                          ready;
    logic [dpil_pkg::WORD_W-1:0]   image_word;
    logic                          final_word;

    modport source (output valid, output image_word, output final_word, input ready);
    modport sink   (input valid, input image_word, input final_word, output ready);
endinterface

interface dpil_wr_if;
    logic                          valid;
    logic                          ready;
    logic [dpil_pkg::OFFSET_W-1:0] write_offset;
    logic [dpil_pkg::WORD_W-1:0]   write_value;
    logic [dpil_pkg::KIND_W-1:0]   memory_kind;
    logic                          run_end;

    modport source (output valid, output write_offset, output write_value,
                    output memory_kind, output run_end, input ready);
    modport sink   (input valid, input write_offset, input write_value,
                    input memory_kind, input run_end, output ready);
endinterface

/* rtl/dpil_front.sv */
module dpil_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dpil_word_if.sink       i_word,
    input  logic            i_full,
    output logic            o_push,
    output dpil_pkg::t_cmd  o_cmd
);

    dpil_pkg::t_phase                r_phase, n_phase;
    logic [dpil_pkg::WORD_W-1:0]     r_left, n_left;
    logic [dpil_pkg::WORD_W-1:0]     r_addr, n_addr;
    logic [dpil_pkg::WORD_W-1:0]     r_low, n_low;
    logic                            r_done, n_done;
    logic                            accept;
    logic [dpil_pkg::WORD_W-1:0]     used;
    logic [dpil_pkg::WORD_W-1:0]     w;

    assign i_word.ready = !i_full;
    assign accept       = i_word.valid && i_word.ready;
    assign w            = i_word.image_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dpil_pkg::PH_COUNT;
            r_left  <= '0;
            r_addr  <= '0;
            r_low   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_addr  <= n_addr;
            r_low   <= n_low;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_addr  = r_addr;
        n_low   = r_low;
        n_done  = r_done;
        o_push  = 1'b0;
        o_cmd   = '{addr: r_addr, low_word: r_low, value: w, two_writes: 1'b0};
        used    = '0;
        if (accept && !r_done) begin
            case (r_phase)
                dpil_pkg::PH_COUNT: begin
                    if (w == dpil_pkg::TERMINATOR_WORD) begin
                        n_done = 1'b1;
                    end else begin
                        n_left  = w;
                        n_phase = dpil_pkg::PH_ADDR;
                    end
                end
                dpil_pkg::PH_ADDR: begin
                    n_addr  = w;
                    n_phase = (r_left == '0) ? dpil_pkg::PH_COUNT : dpil_pkg::PH_DATA;
                end
                dpil_pkg::PH_DATA: begin
                    if (r_addr[dpil_pkg::DATA_SPACE_BIT]) begin
                        o_push = 1'b1;
                        used   = dpil_pkg::WORD_W'(1);
                    end else begin
                        n_low   = w;
                        n_phase = dpil_pkg::PH_HIGH;
                    end
                end
                dpil_pkg::PH_HIGH: begin
                    o_push           = 1'b1;
                    o_cmd.two_writes = 1'b1;
                    used             = dpil_pkg::WORD_W'(2);
                end
                default: begin
                    n_phase = dpil_pkg::PH_COUNT;
                end
            endcase
            if (o_push) begin
                n_addr = r_addr + dpil_pkg::WORD_W'(1);
                if (r_left <= used) begin
                    n_left  = '0;
                    n_phase = dpil_pkg::PH_COUNT;
                end else begin
                    n_left  = r_left - used;
                    n_phase = dpil_pkg::PH_DATA;
                end
            end
        end
        if (accept && i_word.final_word) begin
            n_done = 1'b1;
        end
    end

endmodule

/* rtl/dpil_queue.sv */
`include "dsp_program_image_loader_defines.svh"

module dpil_queue #(
    parameter int Depth = dpil_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dpil_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output dpil_pkg::t_cmd  o_head
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    dpil_pkg::t_cmd  r_mem [Depth];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(Depth - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(Depth - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    `DPIL_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `DPIL_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `DPIL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(Depth), "count overrun")

endmodule

/* rtl/dpil_back.sv */
`include "dsp_program_image_loader_defines.svh"

module dpil_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dpil_pkg::DSP_W-1:0]   i_dsp_index,
    input  logic                         i_cmd_valid,
    input  dpil_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    dpil_wr_if.source                    o_wr
);

    logic                          r_valid, n_valid;
    logic                          r_second, n_second;
    logic [dpil_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [dpil_pkg::WORD_W-1:0]   r_value, n_value;
    dpil_pkg::t_kind               r_kind, n_kind;
    logic                          r_run_end, n_run_end;
    logic                          load;
    logic                          half;

    assign o_wr.valid        = r_valid;
    assign o_wr.write_offset = r_offset;
    assign o_wr.write_value  = r_value;
    assign o_wr.memory_kind  = r_kind;
    assign o_wr.run_end      = r_run_end;

    assign load = !r_valid || o_wr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
        r_offset  <= n_offset;
        r_value   <= n_value;
        r_kind    <= n_kind;
        r_run_end <= n_run_end;
    end

    always_comb begin
        n_valid   = r_valid;
        n_second  = r_second;
        n_offset  = r_offset;
        n_value   = r_value;
        n_kind    = r_kind;
        n_run_end = r_run_end;
        o_pop     = 1'b0;
        half      = 1'b0;
        if (load) begin
            n_valid = i_cmd_valid;
            if (i_cmd_valid) begin
                if (i_cmd.two_writes && !r_second) begin
                    n_kind    = dpil_pkg::KIND_PROG_LO;
                    n_value   = i_cmd.low_word;
                    n_run_end = 1'b0;
                    n_second  = 1'b1;
                end else begin
                    half      = i_cmd.two_writes;
                    n_kind    = i_cmd.two_writes ? dpil_pkg::KIND_PROG_HI
                                                 : dpil_pkg::KIND_DATA;
                    n_value   = i_cmd.value;
                    n_run_end = 1'b1;
                    n_second  = 1'b0;
                    o_pop     = 1'b1;
                end
                n_offset = {1'b0, i_dsp_index, half, i_cmd.addr, 2'b00};
            end
        end
    end

    `DPIL_ASSERT_IMP(a_second_has_cmd, i_clk, i_rst_n, r_second,
        i_cmd_valid && i_cmd.two_writes, "high half pending without program command")
    `DPIL_ASSERT_IMP(a_low_not_end, i_clk, i_rst_n, r_valid && r_kind == dpil_pkg::KIND_PROG_LO,
        !r_run_end, "low half marked as run end")
    `DPIL_ASSERT_NXT(a_low_then_high, i_clk, i_rst_n,
        r_valid && o_wr.ready && r_kind == dpil_pkg::KIND_PROG_LO,
        r_valid && r_kind == dpil_pkg::KIND_PROG_HI, "low half not followed by high half")

endmodule

/* rtl/dsp_program_image_loader.sv */
// Channel   Dir  Modport  Payload
// i_word    in   sink     image_word[15:0], final_word
// o_wr      out  source   write_offset[21:0], write_value[15:0], memory_kind[1:0], run_end
// apb       in   -        dsp_index at byte address 0
//
// Takes one image word per cycle while the queue is not full; a data word's write is queued, then registered onto o_wr.
// A program element gives two writes, low half then high half, both issued by the back end.
// The command queue (QueueDepth entries) absorbs output stalls; i_word.ready drops when full.
// Synchronous active-low reset returns the parser to the count word and empties the queue.
module dsp_program_image_loader #(
    parameter int QueueDepth = dpil_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dpil_word_if.sink                         i_word,
    dpil_wr_if.source                         o_wr,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dpil_pkg::PADDR_W-1:0]      paddr,
    input  logic [dpil_pkg::PDATA_W-1:0]      pwdata,
    output logic [dpil_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [dpil_pkg::DSP_W-1:0] r_dsp_index;
    logic                       push;
    logic                       pop;
    logic                       full;
    logic                       cmd_valid;
    dpil_pkg::t_cmd             push_cmd;
    dpil_pkg::t_cmd             head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == dpil_pkg::REG_DSP_INDEX)
                  ? {{(dpil_pkg::PDATA_W - dpil_pkg::DSP_W){1'b0}}, r_dsp_index}
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsp_index <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == dpil_pkg::REG_DSP_INDEX) begin
            r_dsp_index <= pwdata[dpil_pkg::DSP_W-1:0];
        end
    end

    dpil_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    dpil_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_head  (head_cmd)
    );

    dpil_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dsp_index (r_dsp_index),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_wr        (o_wr)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS   = 1530;
    localparam int CHUNK_ITEMS    = 306;
    localparam int SETTLE_CYCLES  = 2 * dpil_pkg::QUEUE_DEPTH + 4;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [dpil_pkg::PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    localparam logic [dpil_pkg::WORD_W-1:0] ADDR_EDGES [4] =
        '{16'h3FF8, 16'h7FF8, 16'hBFF8, 16'hFFF8};

    localparam logic [dpil_pkg::WORD_W-1:0] DIRECTED_WORDS [18] = '{
        16'h0000, 16'h1234,
        16'h0003, 16'h4000, 16'h0000, 16'hFFFF, 16'hA5A5,
        16'h0004, 16'hFFFF, 16'h5A5A, 16'hFFFF, 16'h0000, 16'h1234, 16'h8000,
        16'h0002, 16'h3FFF, 16'h0001, 16'hFFFE
    };

    typedef struct packed {
        logic [dpil_pkg::OFFSET_W-1:0] offset;
        logic [dpil_pkg::WORD_W-1:0]   value;
        logic [dpil_pkg::KIND_W-1:0]   kind;
        logic                          run_end;
    } t_mem_write;

    class image_scoreboard;
        dpil_pkg::t_phase            phase;
        logic [16:0]                 words_left;
        logic [dpil_pkg::WORD_W-1:0] addr;
        logic [dpil_pkg::WORD_W-1:0] held_low;
        bit                          done;
        logic [dpil_pkg::DSP_W-1:0]  dsp;
        t_mem_write                  writes_due[$];
        int                          errors;

        function new();
            phase      = dpil_pkg::PH_COUNT;
            words_left = '0;
            addr       = '0;
            held_low   = '0;
            done       = 1'b0;
            dsp        = '0;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        function void add_write(input logic half, input logic [dpil_pkg::WORD_W-1:0] value,
                                input dpil_pkg::t_kind kind, input logic run_end);
            t_mem_write wr;
            logic [31:0] off;
            off = ({16'd0, addr} + (32'(half) << 16) + (32'(dsp) << 17)) << 2;
            wr.offset  = off[dpil_pkg::OFFSET_W-1:0];
            wr.value   = value;
            wr.kind    = kind;
            wr.run_end = run_end;
            writes_due.push_back(wr);
        endfunction

        function void advance(input int used);
            addr = addr + 16'd1;
            if (words_left <= 17'(used)) begin
                words_left = '0;
                phase      = dpil_pkg::PH_COUNT;
            end else begin
                words_left = words_left - 17'(used);
                phase      = dpil_pkg::PH_DATA;
            end
        endfunction

        function void note_word(input logic [dpil_pkg::WORD_W-1:0] w, input logic fin);
            if (done) return;
            case (phase)
                dpil_pkg::PH_COUNT: begin
                    if (w == dpil_pkg::TERMINATOR_WORD) begin
                        done = 1'b1;
                    end else begin
                        words_left = {1'b0, w};
                        phase      = dpil_pkg::PH_ADDR;
                    end
                end
                dpil_pkg::PH_ADDR: begin
                    addr  = w;
                    phase = (words_left == 0) ? dpil_pkg::PH_COUNT : dpil_pkg::PH_DATA;
                end
                dpil_pkg::PH_DATA: begin
                    if (addr[dpil_pkg::DATA_SPACE_BIT]) begin
                        add_write(1'b0, w, dpil_pkg::KIND_DATA, 1'b1);
                        advance(1);
                    end else begin
                        held_low = w;
                        phase    = dpil_pkg::PH_HIGH;
                    end
                end
                default: begin
                    add_write(1'b0, held_low, dpil_pkg::KIND_PROG_LO, 1'b0);
                    add_write(1'b1, w, dpil_pkg::KIND_PROG_HI, 1'b1);
                    advance(2);
                end
            endcase
            if (fin) done = 1'b1;
        endfunction

        task check_write(input t_mem_write got);
            t_mem_write want;
            if (writes_due.size() == 0) begin
                report($sformatf("unexpected write offset %h value %h", got.offset, got.value));
                return;
            end
            want = writes_due.pop_front();
            if (got.offset !== want.offset)
                report($sformatf("write_offset %h, want %h", got.offset, want.offset));
            if (got.value !== want.value)
                report($sformatf("write_value %h, want %h", got.value, want.value));
            if (got.kind !== want.kind)
                report($sformatf("memory_kind %0d, want %0d", got.kind, want.kind));
            if (got.run_end !== want.run_end)
                report($sformatf("run_end %b, want %b", got.run_end, want.run_end));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [dpil_pkg::PADDR_W-1:0] paddr;
    logic [dpil_pkg::PDATA_W-1:0] pwdata;
    logic [dpil_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    dpil_word_if w_if();
    dpil_wr_if   wr_if();

    image_scoreboard sb = new();
    bit idle_on = 1'b1;
    int quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    dsp_program_image_loader DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (w_if),
        .o_wr    (wr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    task automatic send_word(input logic [dpil_pkg::WORD_W-1:0] w, input logic fin);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            w_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w_if.valid      <= 1'b1;
        w_if.image_word <= w;
        w_if.final_word <= fin;
        do @(posedge i_clk); while (!w_if.ready);
        sb.note_word(w, fin);
    endtask

    // drop valid, wait out every pending write, then let the block settle
    task automatic pause_input(input int settle);
        w_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.writes_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [dpil_pkg::PADDR_W-1:0] addr,
                             input logic [dpil_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [dpil_pkg::PADDR_W-1:0] addr,
                            output logic [dpil_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dsp(input logic [dpil_pkg::DSP_W-1:0] val);
        logic [dpil_pkg::PDATA_W-1:0] rd;
        pause_input(SETTLE_CYCLES);
        apb_write(dpil_pkg::REG_DSP_INDEX,
                  {{(dpil_pkg::PDATA_W-dpil_pkg::DSP_W){1'b0}}, val});
        apb_write(ADDR_UNUSED, $urandom);
        apb_read(dpil_pkg::REG_DSP_INDEX, rd);
        if (rd !== {{(dpil_pkg::PDATA_W-dpil_pkg::DSP_W){1'b0}}, val})
            sb.report($sformatf("dsp_index reads %h after writing %h", rd, val));
        sb.dsp = val;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (w_if.valid && w_if.ready) || (wr_if.valid && wr_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_mem_write got;
        int stall;
        wr_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                wr_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            wr_if.ready <= 1'b1;
            do @(posedge i_clk); while (!wr_if.valid);
            got.offset  = wr_if.write_offset;
            got.value   = wr_if.write_value;
            got.kind    = wr_if.memory_kind;
            got.run_end = wr_if.run_end;
            sb.check_write(got);
        end
    end

    initial begin
        logic [dpil_pkg::WORD_W-1:0] word;
        logic [dpil_pkg::DSP_W-1:0]  dsp_plan [5];
        bit                          big_plan;
        int                          roll;

        i_rst_n         <= 1'b0;
        w_if.valid      <= 1'b0;
        w_if.image_word <= '0;
        w_if.final_word <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_dsp(2'd3);
        foreach (DIRECTED_WORDS[k]) send_word(DIRECTED_WORDS[k], 1'b0);

        dsp_plan = '{2'd1, 2'd0, 2'd2, 2'd3, 2'($urandom)};
        big_plan = 1'($urandom_range(0, 1));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % CHUNK_ITEMS == 0) set_dsp(dsp_plan[n / CHUNK_ITEMS]);
            if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (n % 250 == 125) pause_input(0);
            case (sb.phase)
                dpil_pkg::PH_COUNT: begin
                    roll = $urandom_range(0, 99);
                    if (big_plan && RANDOM_ITEMS - n < 120) begin
                        word     = 16'hFFFE;
                        big_plan = 1'b0;
                    end else if (roll < 8) begin
                        word = 16'd0;
                    end else if (roll < 80) begin
                        word = 16'($urandom_range(1, 12));
                    end else if (roll < 95) begin
                        word = 16'($urandom_range(13, 64));
                    end else begin
                        word = 16'($urandom_range(65, 300));
                    end
                end
                dpil_pkg::PH_ADDR: begin
                    if ($urandom_range(0, 1))
                        word = 16'($urandom);
                    else
                        word = ADDR_EDGES[$urandom_range(0, 3)] + 16'($urandom_range(0, 15));
                end
                default: word = 16'($urandom);
            endcase
            send_word(word, 1'b0);
        end

        // close the image, then feed words that must be ignored
        idle_on = 1'b1;
        if (sb.phase == dpil_pkg::PH_COUNT && $urandom_range(0, 1))
            send_word(dpil_pkg::TERMINATOR_WORD, 1'b0);
        else
            send_word(16'($urandom), 1'b1);
        for (int k = 0; k < 6; k++)
            send_word(16'($urandom), (k == 5) ? 1'b1 : 1'($urandom_range(0, 1)));

        pause_input(20);
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
